>>> design/udec_pkg.sv
// Package for the unsigned binary to decimal ASCII converter.
// Holds widths, pipeline sizing and the stage payload type; no dependencies.
`timescale 1ns / 1ps

package udec_pkg;

    // Width of the converted number
    localparam int VALUE_WIDTH     = 16;
    // Decimal digits of 2**VALUE_WIDTH - 1: floor(VALUE_WIDTH * log10(2)) + 1
    localparam int NUM_DIGITS      = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_WIDTH       = 4 * NUM_DIGITS;
    localparam int DIGIT_IDX_WIDTH = $clog2(NUM_DIGITS);

    // Shift-and-add-3 steps done by one pipeline stage
    localparam int STEPS_PER_STAGE = 4;
    localparam int NUM_STAGES      = (VALUE_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    // Binary operand is zero-extended so every stage consumes the same number of bits
    localparam int PAD_WIDTH       = NUM_STAGES * STEPS_PER_STAGE;

    // Stream widths
    localparam int S_DATA_WIDTH    = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int CHAR_WIDTH      = 6;
    localparam int M_DATA_WIDTH    = 8;

    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = CHAR_WIDTH'(48);

    // Payload carried from stage to stage
    typedef struct packed {
        logic [BCD_WIDTH-1:0] bcd;
        logic [PAD_WIDTH-1:0] bin;
    } work_t;

endpackage

>>> design/udec_dabble_stage.sv
// One pipeline stage of the shift-and-add-3 conversion (STEPS_PER_STAGE steps).
// Depends on udec_pkg for widths and the work_t payload type.
`timescale 1ns / 1ps

module udec_dabble_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  udec_pkg::work_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output udec_pkg::work_t out_data
);

    logic            valid_reg;
    logic            valid_next;
    udec_pkg::work_t data_reg;
    udec_pkg::work_t step_data;

    // Adjust every digit of five or more, then shift the next binary bit in
    always_comb begin
        udec_pkg::work_t w;
        logic [3:0]      dig;
        w = in_data;
        for (int s = 0; s < udec_pkg::STEPS_PER_STAGE; s++) begin
            for (int d = 0; d < udec_pkg::NUM_DIGITS; d++) begin
                dig = w.bcd[d*4 +: 4];
                if (dig >= 4'd5) begin
                    w.bcd[d*4 +: 4] = dig + 4'd3;
                end
            end
            w.bcd = {w.bcd[udec_pkg::BCD_WIDTH-2:0], w.bin[udec_pkg::PAD_WIDTH-1]};
            w.bin = {w.bin[udec_pkg::PAD_WIDTH-2:0], 1'b0};
        end
        step_data = w;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= step_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> design/udec_serializer.sv
// Emits the finished BCD digits one per cycle while m_tready is high, most significant first, leading zeros dropped.
// Depends on udec_pkg for widths and the ASCII offset.
`timescale 1ns / 1ps

module udec_serializer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [udec_pkg::BCD_WIDTH-1:0]      in_bcd,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [udec_pkg::M_DATA_WIDTH-1:0]   m_tdata,
    output logic                                m_tlast
);

    logic                                  busy_reg;
    logic                                  busy_next;
    logic [udec_pkg::DIGIT_IDX_WIDTH-1:0]  idx_reg;
    logic [udec_pkg::DIGIT_IDX_WIDTH-1:0]  idx_next;
    logic [udec_pkg::BCD_WIDTH-1:0]        bcd_reg;
    logic [udec_pkg::BCD_WIDTH-1:0]        bcd_next;
    logic [udec_pkg::DIGIT_IDX_WIDTH-1:0]  lead_idx;
    logic [3:0]                            digit;
    logic                                  final_digit;

    // Highest nonzero digit; zero keeps the units digit
    always_comb begin
        lead_idx = '0;
        for (int i = 0; i < udec_pkg::NUM_DIGITS; i++) begin
            if (in_bcd[i*4 +: 4] != 4'd0) begin
                lead_idx = udec_pkg::DIGIT_IDX_WIDTH'(i);
            end
        end
    end

    assign final_digit = (idx_reg == '0);
    assign in_ready    = !busy_reg || (m_tready && final_digit);

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        bcd_next  = bcd_reg;
        if (busy_reg && m_tready) begin
            if (final_digit) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg - 1'b1;
            end
        end
        if (in_valid && in_ready) begin
            busy_next = 1'b1;
            idx_next  = lead_idx;
            bcd_next  = in_bcd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        bcd_reg <= bcd_next;
    end

    assign digit    = bcd_reg[{idx_reg, 2'b00} +: 4];
    assign m_tvalid = busy_reg;
    assign m_tdata  = udec_pkg::M_DATA_WIDTH'(udec_pkg::ASCII_ZERO + {2'b00, digit});
    assign m_tlast  = final_digit;

endmodule

>>> design/unsigned_to_decimal_ascii.sv
// Top level of the unsigned binary to decimal ASCII converter.
// Depends on udec_pkg, udec_dabble_stage and udec_serializer.
`timescale 1ns / 1ps

// Converts one unsigned number per request on the s_ side into its decimal text on the
// m_ side: one ASCII digit per request, most significant first, leading zeros dropped,
// a zero giving the single character '0', and m_tlast set on the units digit. The binary
// to BCD conversion runs as a pipeline of NUM_STAGES register stages (four at 16 bits),
// each doing four shift-and-add-3 steps. The output stage then sends one digit per cycle
// while m_tready is high; a number has 1 to 5 digits at 16 bits. The pipeline keeps
// taking new numbers while the current text is being sent and holds them when the
// output stalls.
module unsigned_to_decimal_ascii (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [udec_pkg::S_DATA_WIDTH-1:0]   s_tdata,   // [15:0] value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [udec_pkg::M_DATA_WIDTH-1:0]   m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic                                m_tlast    // last_digit
);

    logic            stage_valid [udec_pkg::NUM_STAGES+1];
    logic            stage_ready [udec_pkg::NUM_STAGES+1];
    udec_pkg::work_t stage_data  [udec_pkg::NUM_STAGES+1];

    // Feed the pipeline: empty BCD, binary value zero-extended to the padded width
    assign stage_valid[0]    = s_tvalid;
    assign s_tready          = stage_ready[0];
    assign stage_data[0].bcd = '0;
    assign stage_data[0].bin = udec_pkg::PAD_WIDTH'(s_tdata[udec_pkg::VALUE_WIDTH-1:0]);

    // Conversion pipeline; each stage holds its request while the next one is full
    for (genvar g = 0; g < udec_pkg::NUM_STAGES; g++) begin : g_stage
        udec_dabble_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    // Output register: drop leading zeros and send one digit per request
    udec_serializer u_serializer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (stage_valid[udec_pkg::NUM_STAGES]),
        .in_ready (stage_ready[udec_pkg::NUM_STAGES]),
        .in_bcd   (stage_data[udec_pkg::NUM_STAGES].bcd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> design/udec_checker.sv
// Port-level checks for unsigned_to_decimal_ascii, attached by bind.
// Depends on udec_pkg for port widths.
`timescale 1ns / 1ps

module udec_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [udec_pkg::S_DATA_WIDTH-1:0]   s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [udec_pkg::M_DATA_WIDTH-1:0]   m_tdata,
    input logic                                m_tlast
);

    // Set while the next digit sent opens a new number
    logic first_reg;
    logic first_next;

    assign first_next = (m_tvalid && m_tready) ? m_tlast : first_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
        end else begin
            first_reg <= first_next;
        end
    end

    // A waiting number holds until it is taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input request changed while waiting");

    // A stalled digit holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("digit changed while stalled");

    // Only ASCII '0' to '9' leave the block
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:4] == 4'h3 && m_tdata[3:0] <= 4'd9)
        else $error("character is not a decimal digit");

    // A leading '0' only stands alone
    a_no_lead_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && first_reg && m_tdata[3:0] == 4'd0 |-> m_tlast)
        else $error("leading zero emitted");

    // Nothing comes out in the cycle after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind unsigned_to_decimal_ascii udec_checker u_udec_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> tb/testbench.sv
// Self-checking bench for unsigned_to_decimal_ascii: random and corner numbers in,
// decimal digit characters out. Depends on udec_pkg and the converter RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 8;
    localparam int RANDOM_PER_PHASE = 160;
    localparam int NUM_PHASES       = 3;
    // Pipeline depth plus output stage, with margin for late stray digits
    localparam int DRAIN_CYCLES     = udec_pkg::NUM_STAGES + 20;
    // Worst case: ~500 numbers x 5 digits, each digit waiting out long receiver stalls
    localparam int CYCLE_LIMIT      = 400000;
    localparam int MAX_DEC_DIGITS   = 10;
    localparam logic [7:0] CHAR_ZERO = "0";

    // One expected output character
    typedef struct packed {
        logic [udec_pkg::CHAR_WIDTH-1:0] digit_char;
        logic                            last_digit;
    } digit_t;

    logic                              aclk     = 1'b0;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [udec_pkg::S_DATA_WIDTH-1:0] s_tdata  = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [udec_pkg::M_DATA_WIDTH-1:0] m_tdata;
    logic                              m_tlast;

    // Numbers waiting to be offered, and characters owed by the block
    logic [udec_pkg::VALUE_WIDTH-1:0] pending_values[$];
    digit_t                           expected_digits[$];

    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int errors         = 0;
    int numbers_sent   = 0;
    int digits_checked = 0;
    int cycles         = 0;

    // Digit-count bands used to spread random numbers over every output length
    int band_low[5]  = '{0, 10, 100, 1000, 10000};
    int band_high[5] = '{9, 99, 999, 9999, (1 << udec_pkg::VALUE_WIDTH) - 1};

    unsigned_to_decimal_ascii uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [15:0] value
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [5:0] digit_char, [7:6] zero
        .m_tlast  (m_tlast)     // last_digit
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Split a number into decimal characters, most significant first, no leading
    // zeros; zero still yields one '0'. Append them to the expected queue.
    function automatic void queue_decimal_text(input logic [udec_pkg::VALUE_WIDTH-1:0] value);
        logic [3:0]  units[MAX_DEC_DIGITS];
        logic [31:0] rest;
        int          n;
        digit_t      ch;
        rest = 32'(value);
        n    = 0;
        do begin
            units[n] = 4'(rest % 10);
            n++;
            rest = rest / 10;
        end while (rest != 0 && n < MAX_DEC_DIGITS);
        for (int k = n - 1; k >= 0; k--) begin
            ch.digit_char = udec_pkg::CHAR_WIDTH'(CHAR_ZERO + 8'(units[k]));
            ch.last_digit = (k == 0);
            expected_digits.push_back(ch);
        end
    endfunction

    // Mostly numbers drawn per digit-count band, the rest uniform over the full range
    task automatic add_random_values(input int count);
        int band;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(3) == 0) begin
                pending_values.push_back(udec_pkg::VALUE_WIDTH'($urandom));
            end else begin
                band = $urandom_range(4);
                pending_values.push_back(
                    udec_pkg::VALUE_WIDTH'($urandom_range(band_high[band], band_low[band])));
            end
        end
    endtask

    // Wait until every number is taken and every character has come back
    task automatic wait_until_drained();
        while (pending_values.size() != 0 || expected_digits.size() != 0)
            @(negedge aclk);
    endtask

    // Driver: offer the head of the pending queue, hold it until taken,
    // and record what the block owes for each accepted request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                queue_decimal_text(s_tdata[udec_pkg::VALUE_WIDTH-1:0]);
                pending_values.delete(0);
                numbers_sent++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the request steady until the block takes it
            end else if (pending_values.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= udec_pkg::S_DATA_WIDTH'(pending_values[0]);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted character with the oldest one owed,
    // and throttle the result side at random.
    always @(posedge aclk) begin
        digit_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_digits.size() == 0) begin
                    $error("unexpected character: digit_char %0d, last_digit %0b",
                           m_tdata[udec_pkg::CHAR_WIDTH-1:0], m_tlast);
                    errors++;
                end else begin
                    want = expected_digits.pop_front();
                    if (m_tdata[udec_pkg::CHAR_WIDTH-1:0] !== want.digit_char) begin
                        $error("digit_char mismatch: expected %0d, actual %0d",
                               want.digit_char, m_tdata[udec_pkg::CHAR_WIDTH-1:0]);
                        errors++;
                    end
                    if (m_tlast !== want.last_digit) begin
                        $error("last_digit mismatch: expected %0b, actual %0b",
                               want.last_digit, m_tlast);
                        errors++;
                    end
                    if (m_tdata[udec_pkg::M_DATA_WIDTH-1:udec_pkg::CHAR_WIDTH] !== '0) begin
                        $error("tdata padding mismatch: expected 0, actual %0d",
                               m_tdata[udec_pkg::M_DATA_WIDTH-1:udec_pkg::CHAR_WIDTH]);
                        errors++;
                    end
                end
                digits_checked++;
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: drop the run if it hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Corner numbers: zero, every digit-count boundary, full scale, bit patterns
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(0));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(1));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(9));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(10));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(99));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(100));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(999));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(1000));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(9999));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(10000));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(10001));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(59999));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(65534));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(65535));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(16'h8000));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(16'h5555));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(16'hAAAA));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(16'h00FF));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(16'hFF00));
        pending_values.push_back(udec_pkg::VALUE_WIDTH'(0));

        // Phase 0: busy sender, heavy back-pressure.
        // Phase 1: the reverse. Phase 2: both sides run flat out.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            unique case (phase)
                0: begin
                    tx_idle_pct = 27;
                    rx_idle_pct = 79;
                end
                1: begin
                    tx_idle_pct = 79;
                    rx_idle_pct = 27;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            add_random_values(RANDOM_PER_PHASE);
            wait_until_drained();
        end

        // Let any stray character surface before the final verdict
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_digits.size() != 0) begin
            $error("%0d expected characters never arrived", expected_digits.size());
            errors++;
        end

        $display("Converted %0d numbers to %0d checked characters across three pacing phases,",
                 numbers_sent, digits_checked);
        $display("including zero, every digit-length boundary and full scale; %0d errors.",
                 errors);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/udec_pkg.sv
design/udec_dabble_stage.sv
design/udec_serializer.sv
design/unsigned_to_decimal_ascii.sv
design/udec_checker.sv
tb/testbench.sv
